FILE: rtl/core/btint_pkg.sv
// ----------------------------------------------------------------------------
// btint_pkg
// Types and codes shared by the B+ tree internal node table.
// ----------------------------------------------------------------------------
package btint_pkg;

  // Node capacity; the 5-bit index and count fields of the result word
  // are sized for it.
  localparam int MAX_CELLS = 16;

  typedef enum logic [1:0] {
    ACT_INIT   = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_INSERT = 2'd2,
    ACT_UPDATE = 2'd3
  } action_e;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    action_e     action;
    logic [31:0] key;
    logic [31:0] child_page;
    logic [31:0] new_key;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [4:0]  branch_index;
    logic [31:0] found_page;
    logic [4:0]  cell_count;
  } out_word_t;

endpackage

FILE: rtl/core/btint_ram.sv
// ----------------------------------------------------------------------------
// btint_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module btint_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/core/btree_internal_node_table_unit.sv
// ----------------------------------------------------------------------------
// btree_internal_node_table_unit
// One B+ tree internal node: sorted key/page cells plus a right child.
// ----------------------------------------------------------------------------
// Usage:
// A command word enters on the in channel (valid/ready) and exactly one
// result word leaves on the out channel (valid/ready). Init clears the
// cell count and loads the right child; find, insert and update first run
// a lower-bound binary search over the cells with one shared comparator.
// Each halving step is a RAM read, then a compare, and a last search state
// sees the range closed. A dispatch state then acts on the index; find
// reading a cell page adds a fetch state, an insert into the middle moves
// one cell per cycle and then a place state writes the new cell, and a done
// state loads the result register. Ready is low while a word is in work and
// returns as the result is loaded. A finished result waits in the output
// register, and the next word is accepted meanwhile; it completes only once
// that register is free. Reset clears the cell count and the right child.
// Cell contents are not cleared; cells at or above the count are never read.
// ----------------------------------------------------------------------------
module btree_internal_node_table_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  btint_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output btint_pkg::out_word_t out_word_o
);
  import btint_pkg::*;

  localparam int CW = $clog2(MAX_CELLS + 1);
  localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam logic [CW-1:0] MaxCount = CW'(MAX_CELLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_DISPATCH,
    S_FETCH,
    S_SHIFT,
    S_PLACE,
    S_DONE
  } state_e;

  state_e        state_q;
  action_e       act_q;
  logic [31:0]   key_q, page_q, nkey_q;
  logic [CW-1:0] count_q, lo_q, hi_q, mid_q, ptr_q;
  logic [31:0]   rpage_q, rmax_q;
  logic          status_q;
  logic [31:0]   found_q;
  logic          out_valid_q;
  out_word_t     out_q;

  // RAM control
  logic          re;
  logic [AW-1:0] raddr, waddr;
  logic          we_key, we_page;
  logic [31:0]   wkey, wpage, rkey, rpage;

  logic [CW:0]   sum;
  logic [CW-1:0] mid_w, ptr_m1, ptr_m2, cnt_m1;
  logic          idx_lt_cnt, full, goes_right;
  logic [31:0]   idx_ext, cnt_ext;
  logic          out_free;

  assign sum        = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w      = sum[CW:1];
  assign ptr_m1     = ptr_q - CW'(1);
  assign ptr_m2     = ptr_q - CW'(2);
  assign cnt_m1     = count_q - CW'(1);
  assign idx_lt_cnt = lo_q < count_q;
  assign full       = count_q >= MaxCount;
  assign goes_right = key_q > rmax_q;
  assign idx_ext    = 32'(lo_q);
  assign cnt_ext    = 32'(count_q);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    re      = 1'b0;
    raddr   = '0;
    we_key  = 1'b0;
    we_page = 1'b0;
    waddr   = '0;
    wkey    = key_q;
    wpage   = page_q;
    case (state_q)
      S_SEARCH: begin
        if (lo_q != hi_q) begin
          re    = 1'b1;
          raddr = mid_w[AW-1:0];
        end
      end
      S_DISPATCH: begin
        case (act_q)
          ACT_FIND: begin
            re    = idx_lt_cnt;
            raddr = lo_q[AW-1:0];
          end
          ACT_UPDATE: begin
            we_key = idx_lt_cnt;
            waddr  = lo_q[AW-1:0];
            wkey   = nkey_q;
          end
          ACT_INSERT: begin
            if (!full) begin
              if (goes_right) begin
                // The old right child becomes the new last cell.
                we_key  = 1'b1;
                we_page = 1'b1;
                waddr   = count_q[AW-1:0];
                wkey    = rmax_q;
                wpage   = rpage_q;
              end else if (idx_lt_cnt) begin
                // The shift starts from the current last cell.
                re    = 1'b1;
                raddr = cnt_m1[AW-1:0];
              end else begin
                we_key  = 1'b1;
                we_page = 1'b1;
                waddr   = lo_q[AW-1:0];
              end
            end
          end
          default: ;
        endcase
      end
      S_SHIFT: begin
        // Write the cell read last cycle one place up, and read the next one.
        we_key  = 1'b1;
        we_page = 1'b1;
        waddr   = ptr_q[AW-1:0];
        wkey    = rkey;
        wpage   = rpage;
        if (ptr_m1 > lo_q) begin
          re    = 1'b1;
          raddr = ptr_m2[AW-1:0];
        end
      end
      S_PLACE: begin
        we_key  = 1'b1;
        we_page = 1'b1;
        waddr   = lo_q[AW-1:0];
      end
      default: ;
    endcase
  end

  btint_ram #(
    .WIDTH(32),
    .DEPTH(MAX_CELLS)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (we_key),
    .waddr_i(waddr),
    .wdata_i(wkey),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rkey)
  );

  btint_ram #(
    .WIDTH(32),
    .DEPTH(MAX_CELLS)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (we_page),
    .waddr_i(waddr),
    .wdata_i(wpage),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rpage)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      act_q       <= ACT_INIT;
      key_q       <= '0;
      page_q      <= '0;
      nkey_q      <= '0;
      count_q     <= '0;
      rpage_q     <= '0;
      rmax_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      ptr_q       <= '0;
      status_q    <= STATUS_OK;
      found_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q    <= in_word_i.action;
            key_q    <= in_word_i.key;
            page_q   <= in_word_i.child_page;
            nkey_q   <= in_word_i.new_key;
            lo_q     <= '0;
            hi_q     <= count_q;
            status_q <= STATUS_OK;
            found_q  <= '0;
            if (in_word_i.action == ACT_INIT) begin
              count_q <= '0;
              rpage_q <= in_word_i.child_page;
              rmax_q  <= in_word_i.key;
              state_q <= S_DONE;
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          mid_q   <= mid_w;
          state_q <= (lo_q != hi_q) ? S_CMP : S_DISPATCH;
        end
        S_CMP: begin
          if (rkey >= key_q) begin
            hi_q <= mid_q;
          end else begin
            lo_q <= mid_q + CW'(1);
          end
          state_q <= S_SEARCH;
        end
        S_DISPATCH: begin
          case (act_q)
            ACT_FIND: begin
              if (idx_lt_cnt) begin
                state_q <= S_FETCH;
              end else begin
                found_q <= rpage_q;
                state_q <= S_DONE;
              end
            end
            ACT_UPDATE: begin
              if (!idx_lt_cnt) begin
                rmax_q <= nkey_q;
              end
              state_q <= S_DONE;
            end
            ACT_INSERT: begin
              if (full) begin
                status_q <= STATUS_FULL;
                state_q  <= S_DONE;
              end else if (goes_right) begin
                rpage_q <= page_q;
                rmax_q  <= key_q;
                count_q <= count_q + CW'(1);
                state_q <= S_DONE;
              end else if (idx_lt_cnt) begin
                ptr_q   <= count_q;
                state_q <= S_SHIFT;
              end else begin
                count_q <= count_q + CW'(1);
                state_q <= S_DONE;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end
        S_FETCH: begin
          found_q <= rpage;
          state_q <= S_DONE;
        end
        S_SHIFT: begin
          ptr_q <= ptr_m1;
          if (!(ptr_m1 > lo_q)) begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          count_q <= count_q + CW'(1);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result payload; held while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && out_free) begin
      out_q.status       <= status_q;
      out_q.branch_index <= idx_ext[4:0];
      out_q.found_page   <= found_q;
      out_q.cell_count   <= cnt_ext[4:0];
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCount)
    else $error("cell count exceeds node capacity");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we_key && !we_page)
    else $error("cell RAM written while idle");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> lo_q <= hi_q && hi_q <= count_q)
    else $error("binary search bounds out of order");

  a_result_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> state_q == S_IDLE)
    else $error("result loaded without returning to idle");

endmodule
